// ----- sv/spk_pkg.sv -----
`timescale 1ns / 1ps

package spk_pkg;

    // widths of the data path
    localparam int unsigned WordW  = 64;
    localparam int unsigned NumW   = 5;
    localparam int unsigned CountW = 4;
    localparam int unsigned RndW   = 4;
    localparam int unsigned CtrW   = 8;
    localparam int unsigned CfgIdxW = 2;

    typedef logic [WordW-1:0] t_word;
    typedef logic [NumW-1:0][WordW-1:0] t_perm;

    // fixed initialization word and round schedule
    localparam t_word IV_WORD = 64'h80400c0600000000;
    localparam logic [RndW-1:0] RND_FIRST_FULL  = 4'd0;
    localparam logic [RndW-1:0] RND_FIRST_BLOCK = 4'd6;
    localparam logic [RndW-1:0] RND_LAST        = 4'd11;
    localparam logic [RndW-1:0] RC_BASE         = 4'd15;
    localparam int unsigned ROT_A = 19;
    localparam int unsigned ROT_B = 28;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_KEY_HIGH   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_KEY_LOW    = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_NONCE_HIGH = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_NONCE_LOW  = 2'd3;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINISH
    } t_state;

endpackage

// ----- sv/spk_in_if.sv -----
`timescale 1ns / 1ps

interface spk_in_if;
    logic        valid;
    logic        ready;
    logic        start_message;
    logic [63:0] data_in;
    logic [3:0]  byte_count;

    modport source (output valid, start_message, data_in, byte_count, input ready);
    modport sink (input valid, start_message, data_in, byte_count, output ready);
endinterface

// ----- sv/spk_out_if.sv -----
`timescale 1ns / 1ps

interface spk_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_out;
    logic [3:0]  byte_count_out;

    modport source (output valid, data_out, byte_count_out, input ready);
    modport sink (input valid, data_out, byte_count_out, output ready);
endinterface

// ----- sv/spk_round.sv -----
`timescale 1ns / 1ps

module spk_round
    import spk_pkg::*;
(
    input  t_perm           i_state,
    input  logic [RndW-1:0] i_rnd,
    output t_perm           o_state
);

    t_perm w_in;
    t_perm w_pre;

    // round constant into word 2
    always_comb begin
        w_in = i_state;
        w_in[2] = i_state[2] ^ {4'(RC_BASE - i_rnd), 60'd0};
    end

    // per-word xor of each bit with up to 31 bits above it, then the two rotations
    always_comb begin
        for (int w = 0; w < NumW; w++) begin
            w_pre[w] = w_in[w] ^ (w_in[w] >> 16);
            w_pre[w] = w_pre[w] ^ (w_pre[w] >> 8);
            w_pre[w] = w_pre[w] ^ (w_pre[w] >> 4);
            w_pre[w] = w_pre[w] ^ (w_pre[w] >> 2);
            w_pre[w] = w_pre[w] ^ (w_pre[w] >> 1);
            o_state[w] = w_pre[w]
                ^ {w_pre[w][ROT_A-1:0], w_pre[w][WordW-1:ROT_A]}
                ^ {w_pre[w][ROT_B-1:0], w_pre[w][WordW-1:ROT_B]};
        end
    end

endmodule

// ----- sv/sponge_permutation_ctr_keystream.sv -----
`timescale 1ns / 1ps

// channel   dir  payload                                   handshake
// i_blk     in   start_message, data_in[63:0], byte_count  valid / ready
// o_res     out  data_out[63:0], byte_count_out            valid / ready
// cfg       in   i_cfg_idx[1:0], i_cfg_data[63:0]          i_cfg_we
//
// one round per cycle in a single shared round unit: a block word takes the
// accept cycle, the block rounds from RND_FIRST_BLOCK to RND_LAST and the
// finish cycle, which loads its result; a start word first runs 12 full rounds
// from RND_FIRST_FULL, then the block rounds.
// the next word is taken once the finish cycle has loaded the output register,
// even if that result is still waiting; a stalled output holds the finish cycle.
// synchronous active-low reset clears state, counter, keys and output valid.

module sponge_permutation_ctr_keystream
    import spk_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    spk_in_if.sink             i_blk,
    spk_out_if.source          o_res,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [WordW-1:0]   i_cfg_data
);

    t_state            r_state, n_state;
    t_perm             r_perm, n_perm;
    logic [RndW-1:0]   r_rnd, n_rnd;
    logic              r_full, n_full;
    logic [CtrW-1:0]   r_cnt, n_cnt;
    t_word             r_data, n_data;
    logic [CountW-1:0] r_count, n_count;
    logic              r_out_valid, n_out_valid;
    t_word             r_out_data, n_out_data;
    logic [CountW-1:0] r_out_count, n_out_count;
    t_word             r_key_high, r_key_low, r_nonce_high, r_nonce_low;

    t_perm             w_round;
    t_word             w_mask;
    logic [CtrW-1:0]   w_cnt_inc;

    // shared round unit
    spk_round u_round (
        .i_state (r_perm),
        .i_rnd   (r_rnd),
        .o_state (w_round)
    );

    // byte mask from the stored count
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            w_mask[WordW-1-8*b -: 8] = (r_count > 4'(b)) ? 8'hff : 8'h00;
        end
    end

    assign w_cnt_inc = r_cnt + 8'd1;

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_perm      = r_perm;
        n_rnd       = r_rnd;
        n_full      = r_full;
        n_cnt       = r_cnt;
        n_data      = r_data;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_count = r_out_count;

        // result taken
        if (o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_blk.valid) begin
                    n_data  = i_blk.data_in;
                    n_count = i_blk.byte_count;
                    n_state = ST_ROUND;
                    if (i_blk.start_message) begin
                        n_perm[0] = IV_WORD | r_key_high;
                        n_perm[1] = r_key_low;
                        n_perm[2] = r_nonce_high;
                        n_perm[3] = r_nonce_low;
                        n_perm[4] = '0;
                        n_cnt     = '0;
                        n_rnd     = RND_FIRST_FULL;
                        n_full    = 1'b1;
                    end else begin
                        n_rnd  = RND_FIRST_BLOCK;
                        n_full = 1'b0;
                    end
                end
            end
            ST_ROUND: begin
                n_perm = w_round;
                if (r_rnd == RND_LAST) begin
                    if (r_full) begin
                        n_full = 1'b0;
                        n_rnd  = RND_FIRST_BLOCK;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end else begin
                    n_rnd = r_rnd + 4'd1;
                end
            end
            ST_FINISH: begin
                // wait until the output register is free
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = (r_data ^ r_perm[0]) & w_mask;
                    n_out_count = r_count;
                    n_cnt       = w_cnt_inc;
                    n_perm[4]   = r_perm[4] ^ {56'd0, w_cnt_inc};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_perm      <= '0;
            r_cnt       <= '0;
            r_rnd       <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_perm      <= n_perm;
            r_cnt       <= n_cnt;
            r_rnd       <= n_rnd;
            r_full      <= n_full;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_data      <= n_data;
        r_count     <= n_count;
        r_out_data  <= n_out_data;
        r_out_count <= n_out_count;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high   <= '0;
            r_key_low    <= '0;
            r_nonce_high <= '0;
            r_nonce_low  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY_HIGH:   r_key_high   <= i_cfg_data;
                CFG_KEY_LOW:    r_key_low    <= i_cfg_data;
                CFG_NONCE_HIGH: r_nonce_high <= i_cfg_data;
                CFG_NONCE_LOW:  r_nonce_low  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ports
    assign i_blk.ready          = (r_state == ST_IDLE);
    assign o_res.valid          = r_out_valid;
    assign o_res.data_out       = r_out_data;
    assign o_res.byte_count_out = r_out_count;

endmodule

// ----- sv/spk_checker.sv -----
`timescale 1ns / 1ps

module spk_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_in_start,
    input logic i_out_valid,
    input logic i_out_ready
);

    // a held result stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // busy right after a word is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after accept");

    // a start word keeps the block busy through all eighteen rounds
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_start |=> ##17 !i_in_ready)
        else $error("start word finished too early");

    // a new result appears only out of a busy cycle
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result without work");

    // reset empties the output
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind sponge_permutation_ctr_keystream spk_checker u_spk_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_blk.valid),
    .i_in_ready  (i_blk.ready),
    .i_in_start  (i_blk.start_message),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready)
);

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import spk_pkg::*;

    localparam int unsigned CycleLimit = 1_000_000;
    localparam int unsigned ItemGoal   = 2000;

    typedef struct packed {
        t_word              data;
        logic [CountW-1:0]  count;
    } t_cipher_word;

    // keystream predictor and store of expected cipher words
    class keystream_scoreboard;
        t_word             key_hi, key_lo, nonce_hi, nonce_lo;
        t_word             perm[NumW];
        logic [CtrW-1:0]   blk_ctr;
        t_cipher_word      expected_cipher_q[$];
        int unsigned       failures;

        function new();
            key_hi = '0;
            key_lo = '0;
            nonce_hi = '0;
            nonce_lo = '0;
            foreach (perm[w]) perm[w] = '0;
            blk_ctr = '0;
            failures = 0;
        endfunction

        function void note_register(logic [CfgIdxW-1:0] idx, t_word value);
            case (idx)
                CFG_KEY_HIGH:   key_hi = value;
                CFG_KEY_LOW:    key_lo = value;
                CFG_NONCE_HIGH: nonce_hi = value;
                CFG_NONCE_LOW:  nonce_lo = value;
                default: ;
            endcase
        endfunction

        // rounds from first_rnd through the last one
        function void permute(int unsigned first_rnd);
            logic [RndW-1:0] rnd;
            logic [7:0]      rc;
            t_word           x;
            for (int unsigned r = first_rnd; r <= RND_LAST; r++) begin
                rnd = r[RndW-1:0];
                rc = 8'hf0 ^ {rnd, 4'h0};
                perm[2] ^= {rc, 56'h0};
                for (int w = 0; w < NumW; w++) begin
                    x = perm[w];
                    x ^= x >> 16;
                    x ^= x >> 8;
                    x ^= x >> 4;
                    x ^= x >> 2;
                    x ^= x >> 1;
                    x ^= {x[18:0], x[63:19]} ^ {x[27:0], x[63:28]};
                    perm[w] = x;
                end
            end
        endfunction

        // advance the sponge for one accepted word and queue its cipher word
        function void predict_cipher(logic start, t_word data, logic [CountW-1:0] count);
            t_word        keep;
            t_cipher_word res;
            if (start) begin
                perm[0] = IV_WORD | key_hi;
                perm[1] = key_lo;
                perm[2] = nonce_hi;
                perm[3] = nonce_lo;
                perm[4] = '0;
                blk_ctr = '0;
                permute(RND_FIRST_FULL);
            end
            permute(RND_FIRST_BLOCK);
            if (count == 0)
                keep = '0;
            else if (count >= 8)
                keep = '1;
            else
                keep = {WordW{1'b1}} << (64 - 8 * int'(count));
            res.data = (data ^ perm[0]) & keep;
            res.count = count;
            expected_cipher_q.push_back(res);
            blk_ctr = blk_ctr + 1'b1;
            perm[4] ^= {56'h0, blk_ctr};
        endfunction

        function void check_cipher(t_word data, logic [CountW-1:0] count);
            t_cipher_word exp_w;
            if (expected_cipher_q.size() == 0) begin
                $error("cipher word %h with nothing expected", data);
                failures++;
                return;
            end
            exp_w = expected_cipher_q.pop_front();
            if (data !== exp_w.data) begin
                $error("data_out: expected %h, actual %h", exp_w.data, data);
                failures++;
            end
            if (count !== exp_w.count) begin
                $error("byte_count_out: expected %0d, actual %0d", exp_w.count, count);
                failures++;
            end
        endfunction

        function int unsigned pending();
            return expected_cipher_q.size();
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_idx;
    logic [WordW-1:0]    i_cfg_data;

    spk_in_if  blk_if ();
    spk_out_if res_if ();

    keystream_scoreboard sb = new();
    int unsigned         items_sent = 0;
    int unsigned         cycles = 0;
    bit                  quiet = 1'b0;

    sponge_permutation_ctr_keystream dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_blk      (blk_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // mostly short gaps, a few long ones, none in quiet stretches
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 30);
    endfunction

    function automatic t_word pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input t_word value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        sb.note_register(idx, value);
    endtask

    task automatic load_key_nonce(input t_word kh, input t_word kl,
                                  input t_word nh, input t_word nl);
        write_reg(CFG_KEY_HIGH, kh);
        write_reg(CFG_KEY_LOW, kl);
        write_reg(CFG_NONCE_HIGH, nh);
        write_reg(CFG_NONCE_LOW, nl);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_word(input logic start, input t_word data,
                             input logic [CountW-1:0] count);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            blk_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        blk_if.valid <= 1'b1;
        blk_if.start_message <= start;
        blk_if.data_in <= data;
        blk_if.byte_count <= count;
        do @(posedge i_clk); while (!blk_if.ready);
        sb.predict_cipher(start, data, count);
        items_sent++;
    endtask

    // well-formed message: start word, full words, then a possibly short tail
    task automatic send_message(input int unsigned n_words, input logic [CountW-1:0] tail);
        for (int unsigned k = 0; k < n_words; k++)
            send_word(k == 0, pick_word(), (k == n_words - 1) ? tail : 4'd8);
    endtask

    // drop valid and wait until every cipher word has come back
    task automatic wait_idle();
        blk_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // result side with random stalls
    initial begin : cipher_sink
        int unsigned stall;
        stall = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready)
                sb.check_cipher(res_if.data_out, res_if.byte_count_out);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                stall--;
            end else begin
                res_if.ready <= 1'b1;
                if ($urandom_range(0, 5) == 0)
                    stall = pick_gap();
            end
        end
    end

    // stimulus
    initial begin : stimulus
        int unsigned phase;
        int unsigned n_msg;
        int unsigned n_words;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_KEY_HIGH;
        i_cfg_data <= '0;
        blk_if.valid <= 1'b0;
        blk_if.start_message <= 1'b0;
        blk_if.data_in <= '0;
        blk_if.byte_count <= 4'd8;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no start after reset: all-zero state
        send_word(1'b0, '0, 4'd8);
        send_word(1'b0, '1, 4'd8);

        // all-ones key and nonce, zero, oversize and short counts
        wait_idle();
        load_key_nonce('1, '1, '1, '1);
        send_word(1'b1, '1, 4'd8);
        send_word(1'b0, pick_word(), 4'd0);
        send_word(1'b0, pick_word(), 4'd9);
        send_word(1'b0, pick_word(), 4'd15);
        for (int c = 1; c < 8; c++)
            send_word(1'b0, {$urandom, $urandom}, c[CountW-1:0]);
        send_word(1'b1, '0, 4'd8);
        send_word(1'b1, {$urandom, $urandom}, 4'd3);

        // all-zero key and nonce
        wait_idle();
        load_key_nonce('0, '0, '0, '0);
        send_word(1'b1, '0, 4'd8);
        send_word(1'b0, {$urandom, $urandom}, 4'd8);

        // random key and nonce
        wait_idle();
        load_key_nonce({$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom}, {$urandom, $urandom});
        send_word(1'b1, '1, 4'd15);
        send_word(1'b0, '0, 4'd0);

        // random messages, a long one to wrap the block counter, some noise
        phase = 0;
        while (items_sent < ItemGoal) begin
            wait_idle();
            load_key_nonce(pick_word(), pick_word(), pick_word(), pick_word());
            n_msg = $urandom_range(1, 6);
            for (int unsigned m = 0; m < n_msg; m++) begin
                quiet = ($urandom_range(0, 4) == 0);
                if (phase == 2 && m == 0) begin
                    send_message(300, CountW'($urandom_range(1, 8)));
                end else if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 4))
                        send_word(1'($urandom_range(0, 1)), pick_word(),
                                  CountW'($urandom_range(0, 15)));
                end else begin
                    if ($urandom_range(0, 9) == 0)
                        n_words = $urandom_range(9, 40);
                    else
                        n_words = $urandom_range(1, 8);
                    send_message(n_words, CountW'($urandom_range(1, 8)));
                end
            end
            phase++;
        end
        quiet = 1'b0;

        // drain, then let the pipeline settle
        wait_idle();
        repeat (25) @(posedge i_clk);
        if (sb.failures == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
